// ===== hw/rtl/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared sizes, codes and helpers of the paged frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

   localparam int MAX_FRAMES = 512;
   localparam int MAX_PROCS  = 32;

   localparam int ID_W    = 16;
   localparam int SIZE_W  = 21;
   localparam int FS_W    = 13;
   localparam int CNT_W   = 10;
   localparam int IDX_W   = 9;
   localparam int STAT_W  = 3;
   localparam int KIND_W  = 2;
   localparam int CSR_W   = 13;

   localparam int FA_W    = $clog2(MAX_FRAMES);
   localparam int FC_W    = $clog2(MAX_FRAMES + 1);
   localparam int RP_W    = $clog2(MAX_PROCS);
   localparam int FENT_W  = ID_W + 1;
   localparam int REC_W   = ID_W + SIZE_W;

   localparam logic [FS_W-1:0]  FRAME_SIZE_RESET = FS_W'(4);
   localparam logic [CNT_W-1:0] FRAME_CNT_RESET  = CNT_W'(512);

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC   = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_QUERY   = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK         = 3'd0,
      ST_NO_FREE    = 3'd1,
      ST_TOO_FEW    = 3'd2,
      ST_NOT_FOUND  = 3'd3,
      ST_TABLE_FULL = 3'd4,
      ST_DUPLICATE  = 3'd5
   } status_type;

   typedef enum logic {
      REG_FRAME_SIZE = 1'b0,
      REG_FRAME_CNT  = 1'b1
   } csr_index_type;

   // frame count register clipped to the frame store depth
   function automatic logic [FC_W-1:0] eff_count(input logic [CNT_W-1:0] v);
      logic [FC_W-1:0] r;
      if (32'(v) > MAX_FRAMES) begin
         r = FC_W'(MAX_FRAMES);
      end else begin
         r = FC_W'(v);
      end
      return r;
   endfunction

   // zero frame size counts as one
   function automatic logic [FS_W-1:0] eff_size(input logic [FS_W-1:0] v);
      return (v == '0) ? FS_W'(1) : v;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pfa_ram.sv =====
// ----------------------------------------------------------------------------
// pfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pfa_div.sv =====
// ----------------------------------------------------------------------------
// pfa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [pfa_pkg::SIZE_W-1:0] dividend,
   input  wire logic [pfa_pkg::FS_W-1:0]   divisor,
   output      logic                      done,
   output      logic [pfa_pkg::SIZE_W-1:0] quotient,
   output      logic [pfa_pkg::FS_W-1:0]   remainder
);

   import pfa_pkg::*;

   localparam int STEP_W = $clog2(SIZE_W);

   logic                busy_ff;
   logic                done_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [SIZE_W-1:0]   dq_ff;
   logic [FS_W-1:0]     rem_ff;
   logic [FS_W-1:0]     div_ff;
   logic [FS_W:0]       trial;
   logic                ge;

   assign trial = {rem_ff, dq_ff[SIZE_W-1]};
   assign ge    = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            dq_ff   <= dividend;
            rem_ff  <= '0;
            div_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= ge ? FS_W'(trial - {1'b0, div_ff}) : trial[FS_W-1:0];
            dq_ff  <= {dq_ff[SIZE_W-2:0], ge};
            if (step_ff == STEP_W'(SIZE_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff + STEP_W'(1);
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = dq_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/paged_frame_allocator.sv =====
// Steps: query reads the frame RAM; allocate divides, scans the records,
//   writes one, scans frames; release scans records, divides, scans frames.
// Throughput: one transaction at a time; the frame scan over the frame RAM,
//   one entry per cycle, sets the figure.
// Reset: synchronous; afterwards, and after every register write, a clearing
//   pass sweeps every entry of the frame RAM while no request is taken.
// ----------------------------------------------------------------------------
// paged_frame_allocator
// Fixed-size page frame allocator with a sequenced scan and shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_frame_allocator (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_stall,
   input  wire logic [pfa_pkg::KIND_W-1:0]  req_kind,
   input  wire logic [pfa_pkg::ID_W-1:0]    req_process_id,
   input  wire logic [pfa_pkg::SIZE_W-1:0]  req_process_size_kb,
   input  wire logic [pfa_pkg::IDX_W-1:0]   req_frame_index,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   output      logic [pfa_pkg::STAT_W-1:0]  rsp_status,
   output      logic [pfa_pkg::CNT_W-1:0]   rsp_frames_moved,
   output      logic [pfa_pkg::CNT_W-1:0]   rsp_free_frames,
   output      logic [pfa_pkg::SIZE_W-1:0]  rsp_fragmentation_kb,
   output      logic [pfa_pkg::ID_W-1:0]    rsp_owner_id,
   output      logic                        rsp_owner_valid,
   input  wire logic                        csr_write_enable,
   input  wire logic                        csr_index,
   input  wire logic [pfa_pkg::CSR_W-1:0]   csr_wdata
);

   import pfa_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ADIV, S_REC_RD, S_REC_CMP, S_REC_WR,
      S_RDIV, S_FSCAN, S_QREAD, S_FINISH
   } state_type;

   state_type          state_ff;
   logic [FS_W-1:0]    fs_ff;
   logic [CNT_W-1:0]   fcnt_ff;
   logic [FC_W-1:0]    free_ff;
   logic [SIZE_W-1:0]  frag_ff;
   logic [MAX_PROCS-1:0] rec_valid_ff;
   logic [FA_W-1:0]    clr_ff;

   kind_type           kind_ff;
   logic [ID_W-1:0]    id_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic               qrange_ff;
   logic [FC_W-1:0]    need_ff;
   logic [FS_W-1:0]    waste_ff;
   logic [RP_W-1:0]    ridx_ff;
   logic [RP_W-1:0]    slot_ff;
   logic               slot_found_ff;
   logic [FC_W-1:0]    fidx_ff;
   logic [FA_W-1:0]    pidx_ff;
   logic               pend_ff;
   logic [FC_W-1:0]    got_ff;

   status_type         res_status_ff;
   logic [FC_W-1:0]    res_moved_ff;
   logic [ID_W-1:0]    res_owner_ff;
   logic               res_ovalid_ff;

   logic               rsp_valid_ff;
   logic [STAT_W-1:0]  rsp_status_ff;
   logic [CNT_W-1:0]   rsp_moved_ff;
   logic [CNT_W-1:0]   rsp_free_ff;
   logic [SIZE_W-1:0]  rsp_frag_ff;
   logic [ID_W-1:0]    rsp_owner_ff;
   logic               rsp_ovalid_ff;

   // divider
   logic               div_start;
   logic [SIZE_W-1:0]  div_dividend;
   logic               div_done;
   logic [SIZE_W-1:0]  div_quot;
   logic [FS_W-1:0]    div_rem;
   logic [FS_W-1:0]    fs_eff;
   logic [FS_W-1:0]    waste;
   logic [SIZE_W:0]    need_full;

   // frame RAM
   logic               fr_wr_en;
   logic [FA_W-1:0]    fr_wr_addr;
   logic [FENT_W-1:0]  fr_wr_data;
   logic [FA_W-1:0]    fr_rd_addr;
   logic [FENT_W-1:0]  fr_rd_data;

   // record RAM
   logic               rc_wr_en;
   logic [REC_W-1:0]   rc_rd_data;
   logic [ID_W-1:0]    rc_id;
   logic [SIZE_W-1:0]  rc_size;

   logic               req_take;
   logic               is_alloc;
   logic [FC_W-1:0]    limit;
   logic               issue;
   logic               take;
   logic [FC_W-1:0]    got_n;
   logic               scan_done;
   logic               rec_hit;
   logic               rec_last;
   logic               out_free;
   logic               rsp_load;
   logic [CNT_W-1:0]   fcnt_new;

   assign fs_eff = eff_size(fs_ff);
   assign waste  = (div_rem == '0) ? '0 : FS_W'(fs_eff - div_rem);
   // round the frame count up when a partial frame is left
   assign need_full = {1'b0, div_quot} + (SIZE_W+1)'(div_rem != '0);

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = (state_ff == S_FINISH) && out_free && !csr_write_enable;
   assign is_alloc  = (kind_ff == KIND_ALLOC);

   assign rc_id    = rc_rd_data[SIZE_W +: ID_W];
   assign rc_size  = rc_rd_data[SIZE_W-1:0];
   assign rec_hit  = rec_valid_ff[ridx_ff] && (rc_id == id_ff);
   assign rec_last = (ridx_ff == RP_W'(MAX_PROCS - 1));

   // frame scan: read one entry per cycle, act on the previous one
   assign limit = is_alloc ? eff_count(fcnt_ff) : FC_W'(MAX_FRAMES);
   assign issue = (fidx_ff < limit);
   always_comb begin
      if (is_alloc) begin
         take = pend_ff && !fr_rd_data[ID_W] && (got_ff < need_ff);
      end else begin
         take = pend_ff && fr_rd_data[ID_W] && (fr_rd_data[ID_W-1:0] == id_ff);
      end
   end
   assign got_n     = got_ff + FC_W'(take);
   assign scan_done = (!issue && !pend_ff) || (is_alloc && (got_n == need_ff));

   assign fcnt_new = (csr_index == REG_FRAME_CNT) ? csr_wdata[CNT_W-1:0] : fcnt_ff;

   always_comb begin
      fr_wr_en   = 1'b0;
      fr_wr_addr = pidx_ff;
      fr_wr_data = '0;
      if (state_ff == S_CLEAR) begin
         fr_wr_en   = 1'b1;
         fr_wr_addr = clr_ff;
      end else if (state_ff == S_FSCAN) begin
         fr_wr_en   = take;
         fr_wr_data = is_alloc ? {1'b1, id_ff} : '0;
      end
      fr_rd_addr = (state_ff == S_FSCAN) ? fidx_ff[FA_W-1:0] : FA_W'(req_frame_index);
   end

   assign rc_wr_en = (state_ff == S_REC_WR);

   always_comb begin
      div_start    = 1'b0;
      div_dividend = size_ff;
      if (req_take && (kind_type'(req_kind) == KIND_ALLOC) && (free_ff != '0)) begin
         div_start    = 1'b1;
         div_dividend = req_process_size_kb;
      end else if ((state_ff == S_REC_CMP) && !is_alloc && rec_hit) begin
         div_start    = 1'b1;
         div_dividend = rc_size;
      end
   end

   pfa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (fs_eff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   pfa_ram #(.WIDTH(FENT_W), .DEPTH(MAX_FRAMES)) u_frame_ram (
      .clock   (clock),
      .wr_en   (fr_wr_en),
      .wr_addr (fr_wr_addr),
      .wr_data (fr_wr_data),
      .rd_addr (fr_rd_addr),
      .rd_data (fr_rd_data)
   );

   pfa_ram #(.WIDTH(REC_W), .DEPTH(MAX_PROCS)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rc_wr_en),
      .wr_addr (slot_ff),
      .wr_data ({id_ff, size_ff}),
      .rd_addr (ridx_ff),
      .rd_data (rc_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         fs_ff         <= FRAME_SIZE_RESET;
         fcnt_ff       <= FRAME_CNT_RESET;
         free_ff       <= eff_count(FRAME_CNT_RESET);
         frag_ff       <= '0;
         rec_valid_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            // any register write drops every allocation
            if (csr_index == REG_FRAME_SIZE) begin
               fs_ff <= csr_wdata;
            end else begin
               fcnt_ff <= csr_wdata[CNT_W-1:0];
            end
            free_ff      <= eff_count(fcnt_new);
            frag_ff      <= '0;
            rec_valid_ff <= '0;
            clr_ff       <= '0;
            state_ff     <= S_CLEAR;
         end else begin
            unique case (state_ff)
               S_CLEAR: begin
                  clr_ff <= clr_ff + FA_W'(1);
                  if (clr_ff == FA_W'(MAX_FRAMES - 1)) begin
                     state_ff <= S_IDLE;
                  end
               end
               S_IDLE: begin
                  if (req_take) begin
                     kind_ff       <= kind_type'(req_kind);
                     id_ff         <= req_process_id;
                     size_ff       <= req_process_size_kb;
                     qrange_ff     <= (32'(req_frame_index) < MAX_FRAMES);
                     res_status_ff <= ST_OK;
                     res_moved_ff  <= '0;
                     res_owner_ff  <= '0;
                     res_ovalid_ff <= 1'b0;
                     ridx_ff       <= '0;
                     slot_found_ff <= 1'b0;
                     unique case (kind_type'(req_kind))
                        KIND_ALLOC: begin
                           if (free_ff == '0) begin
                              res_status_ff <= ST_NO_FREE;
                              state_ff      <= S_FINISH;
                           end else begin
                              state_ff <= S_ADIV;
                           end
                        end
                        KIND_RELEASE: state_ff <= S_REC_RD;
                        KIND_QUERY:   state_ff <= S_QREAD;
                        default:      state_ff <= S_FINISH;
                     endcase
                  end
               end
               S_ADIV: begin
                  if (div_done) begin
                     waste_ff <= waste;
                     if (need_full > (SIZE_W+1)'(free_ff)) begin
                        res_status_ff <= ST_TOO_FEW;
                        state_ff      <= S_FINISH;
                     end else begin
                        need_ff  <= FC_W'(need_full);
                        state_ff <= S_REC_RD;
                     end
                  end
               end
               S_REC_RD: begin
                  state_ff <= S_REC_CMP;
               end
               S_REC_CMP: begin
                  if (is_alloc) begin
                     if (!rec_valid_ff[ridx_ff] && !slot_found_ff) begin
                        slot_ff       <= ridx_ff;
                        slot_found_ff <= 1'b1;
                     end
                     if (rec_hit) begin
                        res_status_ff <= ST_DUPLICATE;
                        state_ff      <= S_FINISH;
                     end else if (rec_last) begin
                        if (!slot_found_ff && rec_valid_ff[ridx_ff]) begin
                           res_status_ff <= ST_TABLE_FULL;
                           state_ff      <= S_FINISH;
                        end else begin
                           state_ff <= S_REC_WR;
                        end
                     end else begin
                        ridx_ff  <= ridx_ff + RP_W'(1);
                        state_ff <= S_REC_RD;
                     end
                  end else begin
                     if (rec_hit) begin
                        rec_valid_ff[ridx_ff] <= 1'b0;
                        state_ff              <= S_RDIV;
                     end else if (rec_last) begin
                        res_status_ff <= ST_NOT_FOUND;
                        state_ff      <= S_FINISH;
                     end else begin
                        ridx_ff  <= ridx_ff + RP_W'(1);
                        state_ff <= S_REC_RD;
                     end
                  end
               end
               S_REC_WR: begin
                  rec_valid_ff[slot_ff] <= 1'b1;
                  fidx_ff  <= '0;
                  pend_ff  <= 1'b0;
                  got_ff   <= '0;
                  state_ff <= S_FSCAN;
               end
               S_RDIV: begin
                  if (div_done) begin
                     waste_ff <= waste;
                     fidx_ff  <= '0;
                     pend_ff  <= 1'b0;
                     got_ff   <= '0;
                     state_ff <= S_FSCAN;
                  end
               end
               S_FSCAN: begin
                  got_ff  <= got_n;
                  pidx_ff <= fidx_ff[FA_W-1:0];
                  if (scan_done) begin
                     res_moved_ff <= got_n;
                     if (is_alloc) begin
                        free_ff <= free_ff - got_n;
                        frag_ff <= frag_ff + SIZE_W'(waste_ff);
                     end else begin
                        free_ff <= free_ff + got_n;
                        frag_ff <= (SIZE_W'(waste_ff) > frag_ff) ? '0 :
                                   frag_ff - SIZE_W'(waste_ff);
                     end
                     state_ff <= S_FINISH;
                  end else begin
                     pend_ff <= issue;
                     if (issue) begin
                        fidx_ff <= fidx_ff + FC_W'(1);
                     end
                  end
               end
               S_QREAD: begin
                  if (qrange_ff && fr_rd_data[ID_W]) begin
                     res_owner_ff  <= fr_rd_data[ID_W-1:0];
                     res_ovalid_ff <= 1'b1;
                  end
                  state_ff <= S_FINISH;
               end
               S_FINISH: begin
                  if (out_free) begin
                     rsp_status_ff <= res_status_ff;
                     rsp_moved_ff  <= CNT_W'(res_moved_ff);
                     rsp_free_ff   <= CNT_W'(free_ff);
                     rsp_frag_ff   <= frag_ff;
                     rsp_owner_ff  <= res_owner_ff;
                     rsp_ovalid_ff <= res_ovalid_ff;
                     state_ff      <= S_IDLE;
                  end
               end
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_frames_moved     = rsp_moved_ff;
   assign rsp_free_frames      = rsp_free_ff;
   assign rsp_fragmentation_kb = rsp_frag_ff;
   assign rsp_owner_id         = rsp_owner_ff;
   assign rsp_owner_valid      = rsp_ovalid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pfa_checker.sv =====
// ----------------------------------------------------------------------------
// pfa_checker
// Port-level checks of the paged frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_stall,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   input  wire logic [pfa_pkg::STAT_W-1:0]  rsp_status,
   input  wire logic [pfa_pkg::CNT_W-1:0]   rsp_frames_moved,
   input  wire logic [pfa_pkg::CNT_W-1:0]   rsp_free_frames,
   input  wire logic                        rsp_owner_valid
);

   import pfa_pkg::*;

   // a held result keeps its status, frames moved and free frame count
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_frames_moved) && $stable(rsp_free_frames))
      else $error("rsp transaction changed while stalled");

   a_fail_moves_nothing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_frames_moved == '0)
      else $error("failed request moved frames");

   a_owner_query_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_owner_valid |-> (rsp_status == ST_OK) && (rsp_frames_moved == '0))
      else $error("owner reported with moved frames or error");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_free_frames) <= MAX_FRAMES)
      else $error("free frame count above capacity");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("activity right after reset");

endmodule

bind paged_frame_allocator pfa_checker u_pfa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_frames_moved (rsp_frames_moved),
   .rsp_free_frames  (rsp_free_frames),
   .rsp_owner_valid  (rsp_owner_valid)
);

`default_nettype wire

// ===== dv/tb_paged_frame_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_paged_frame_allocator
// Drives allocate, release and query transactions into the frame allocator
// under random bursts and output stalls, predicts each response with a
// behavioral copy of the frame and record tables, and compares every field.
// ----------------------------------------------------------------------------

module tb_paged_frame_allocator;
   import pfa_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 1200;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [CNT_W-1:0]  moved;
      logic [CNT_W-1:0]  free_frames;
      logic [SIZE_W-1:0] frag;
      logic [ID_W-1:0]   owner;
      logic              owner_valid;
   } alloc_resp_type;

   int error_count = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   class alloc_scoreboard;
      logic [FS_W-1:0]   page_kb;
      logic [CNT_W-1:0]  frame_cnt;
      bit                busy [MAX_FRAMES];
      logic [ID_W-1:0]   owner [MAX_FRAMES];
      bit                rec_live [MAX_PROCS];
      logic [ID_W-1:0]   rec_id [MAX_PROCS];
      logic [SIZE_W-1:0] rec_size [MAX_PROCS];
      int                free_cnt;
      logic [SIZE_W-1:0] frag_sum;
      alloc_resp_type    pending [$];

      function int unit_kb();
         return (page_kb == 0) ? 1 : int'(page_kb);
      endfunction

      function int frame_limit();
         return (int'(frame_cnt) > MAX_FRAMES) ? MAX_FRAMES : int'(frame_cnt);
      endfunction

      function int tail_waste(input int sz);
         int r;
         r = sz % unit_kb();
         return (r == 0) ? 0 : unit_kb() - r;
      endfunction

      function void wipe();
         for (int i = 0; i < MAX_FRAMES; i++) busy[i] = 0;
         for (int i = 0; i < MAX_PROCS; i++) rec_live[i] = 0;
         free_cnt = frame_limit();
         frag_sum = '0;
      endfunction

      function void write_reg(input csr_index_type idx, input logic [CSR_W-1:0] v);
         if (idx == REG_FRAME_SIZE) page_kb = v[FS_W-1:0];
         else frame_cnt = v[CNT_W-1:0];
         wipe();
      endfunction

      function void reset_state();
         page_kb   = FRAME_SIZE_RESET;
         frame_cnt = FRAME_CNT_RESET;
         wipe();
      endfunction

      function int find_id(input logic [ID_W-1:0] id);
         for (int i = 0; i < MAX_PROCS; i++)
            if (rec_live[i] && rec_id[i] == id) return i;
         return -1;
      endfunction

      function void note_request(input kind_type k, input logic [ID_W-1:0] id,
                                 input logic [SIZE_W-1:0] sz, input logic [IDX_W-1:0] fi);
         alloc_resp_type r;
         int need, slot, got;
         r = '0;
         if (k == KIND_ALLOC) begin
            need = int'(sz) / unit_kb() + ((int'(sz) % unit_kb()) != 0);
            slot = -1;
            for (int i = 0; i < MAX_PROCS; i++)
               if (!rec_live[i] && slot < 0) slot = i;
            if (free_cnt == 0) r.status = ST_NO_FREE;
            else if (need > free_cnt) r.status = ST_TOO_FEW;
            else if (find_id(id) >= 0) r.status = ST_DUPLICATE;
            else if (slot < 0) r.status = ST_TABLE_FULL;
            else begin
               rec_live[slot] = 1; rec_id[slot] = id; rec_size[slot] = sz;
               got = 0;
               for (int i = 0; i < frame_limit() && got < need; i++)
                  if (!busy[i]) begin
                     busy[i] = 1; owner[i] = id; got++;
                  end
               free_cnt -= got;
               frag_sum = frag_sum + SIZE_W'(tail_waste(int'(sz)));
               r.moved = CNT_W'(got);
            end
         end else if (k == KIND_RELEASE) begin
            slot = find_id(id);
            if (slot < 0) r.status = ST_NOT_FOUND;
            else begin
               rec_live[slot] = 0;
               got = 0;
               for (int i = 0; i < MAX_FRAMES; i++)
                  if (busy[i] && owner[i] == id) begin
                     busy[i] = 0; got++;
                  end
               free_cnt += got;
               need = tail_waste(int'(rec_size[slot]));
               frag_sum = (need > int'(frag_sum)) ? '0 : frag_sum - SIZE_W'(need);
               r.moved = CNT_W'(got);
            end
         end else if (k == KIND_QUERY) begin
            if (busy[fi]) begin
               r.owner = owner[fi]; r.owner_valid = 1;
            end
         end
         r.free_frames = CNT_W'(free_cnt);
         r.frag = frag_sum;
         pending.push_back(r);
      endfunction

      task check_response(input alloc_resp_type got);
         alloc_resp_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status) report_mismatch("status", got.status, want.status);
         if (got.moved !== want.moved) report_mismatch("frames_moved", got.moved, want.moved);
         if (got.free_frames !== want.free_frames)
            report_mismatch("free_frames", got.free_frames, want.free_frames);
         if (got.frag !== want.frag) report_mismatch("fragmentation", got.frag, want.frag);
         if (got.owner !== want.owner) report_mismatch("owner_id", got.owner, want.owner);
         if (got.owner_valid !== want.owner_valid)
            report_mismatch("owner_valid", got.owner_valid, want.owner_valid);
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind;
   logic [ID_W-1:0]     req_process_id;
   logic [SIZE_W-1:0]   req_process_size_kb;
   logic [IDX_W-1:0]    req_frame_index;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STAT_W-1:0]   rsp_status;
   logic [CNT_W-1:0]    rsp_frames_moved;
   logic [CNT_W-1:0]    rsp_free_frames;
   logic [SIZE_W-1:0]   rsp_fragmentation_kb;
   logic [ID_W-1:0]     rsp_owner_id;
   logic                rsp_owner_valid;
   logic                csr_write_enable;
   logic                csr_index;
   logic [CSR_W-1:0]    csr_wdata;

   paged_frame_allocator uut (.*);

   alloc_scoreboard sb = new();
   int idle_cycles = 0;
   bit stall_random = 1;
   logic [ID_W-1:0] live_ids [$];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // receiver stall pattern: random, periodic and stall-free phases in turn
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (!stall_random || stall_phase[9]) begin
         rsp_stall <= 1'b0;
      end else if (stall_phase[8]) begin
         rsp_stall <= (stall_phase[2:0] < 3'd3);
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response({rsp_status, rsp_frames_moved, rsp_free_frames,
                            rsp_fragmentation_kb, rsp_owner_id, rsp_owner_valid});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic send_request(input kind_type k, input logic [ID_W-1:0] id,
                               input logic [SIZE_W-1:0] sz, input logic [IDX_W-1:0] fi);
      req_valid           <= 1'b1;
      req_kind            <= k;
      req_process_id      <= id;
      req_process_size_kb <= sz;
      req_frame_index     <= fi;
      do @(posedge clock); while (req_stall);
      sb.note_request(k, id, sz, fi);
      if (k == KIND_ALLOC && sb.pending[$].status == ST_OK) live_ids.push_back(id);
      if (k == KIND_RELEASE && sb.pending[$].status == ST_OK)
         foreach (live_ids[i]) if (live_ids[i] == id) begin
            live_ids.delete(i);
            break;
         end
   endtask

   task automatic drop_valid(input int gap);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic wait_drained();
      drop_valid(1);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_W-1:0] v);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.write_reg(idx, v);
      live_ids.delete();
      @(posedge clock);
   endtask

   function automatic logic [SIZE_W-1:0] pick_size();
      int unit;
      unit = sb.unit_kb();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return SIZE_W'($urandom);
         2: return SIZE_W'(unit * $urandom_range(1, 8));
         default: return SIZE_W'($urandom_range(1, unit * 24));
      endcase
   endfunction

   task automatic random_phase(input int count);
      int sent, burst;
      logic [ID_W-1:0] id;
      kind_type k;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst && sent < count; b++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: k = KIND_ALLOC;
               4, 5, 6:    k = KIND_RELEASE;
               7, 8:       k = KIND_QUERY;
               default:    k = KIND_NONE;
            endcase
            if (live_ids.size() != 0 && $urandom_range(0, 3) != 0)
               id = live_ids[$urandom_range(0, live_ids.size() - 1)];
            else if ($urandom_range(0, 1)) id = ID_W'($urandom_range(0, 40));
            else id = ID_W'($urandom);
            send_request(k, id, pick_size(), IDX_W'($urandom));
            sent++;
         end
         if ($urandom_range(0, 2) != 0) drop_valid($urandom_range(1, 30));
      end
   endtask

   initial begin
      req_valid           = 1'b0;
      req_kind            = KIND_NONE;
      req_process_id      = '0;
      req_process_size_kb = '0;
      req_frame_index     = '0;
      csr_write_enable    = 1'b0;
      csr_index           = REG_FRAME_SIZE;
      csr_wdata           = '0;
      reset               = 1'b1;
      sb.reset_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every kind, each corner case at reset settings
      send_request(KIND_QUERY, '0, '0, '0);
      send_request(KIND_RELEASE, 16'd7, '0, '0);
      send_request(KIND_ALLOC, 16'd1, '0, '0);
      send_request(KIND_ALLOC, 16'd1, 21'd5, '0);
      send_request(KIND_ALLOC, 16'hFFFF, 21'd9, '0);
      send_request(KIND_ALLOC, 16'd2, 21'h1FFFFF, '0);
      send_request(KIND_QUERY, '0, '0, 9'd0);
      send_request(KIND_QUERY, '0, '0, 9'd2);
      send_request(KIND_QUERY, '0, '0, 9'h1FF);
      send_request(KIND_NONE, 16'hFFFF, 21'h1FFFFF, 9'h1FF);
      send_request(KIND_ALLOC, 16'd3, 21'd2036, '0);
      send_request(KIND_ALLOC, 16'd4, 21'd4, '0);
      send_request(KIND_QUERY, '0, '0, 9'd511);
      send_request(KIND_RELEASE, 16'hFFFF, '0, '0);
      send_request(KIND_RELEASE, 16'd1, '0, '0);
      for (int i = 0; i < 33; i++) send_request(KIND_ALLOC, ID_W'(100 + i), '0, '0);
      wait_drained();

      // zero frame count: every allocate fails for lack of frames
      write_csr(REG_FRAME_CNT, '0);
      send_request(KIND_ALLOC, 16'd9, 21'd1, '0);
      send_request(KIND_ALLOC, 16'd9, '0, '0);
      wait_drained();

      // settings sweep, extremes included; random traffic in each
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_csr(REG_FRAME_SIZE, '0);
               write_csr(REG_FRAME_CNT, CSR_W'(1));
            end
            1: begin
               write_csr(REG_FRAME_SIZE, CSR_W'(13'h1FFF));
               write_csr(REG_FRAME_CNT, CSR_W'(10'h3FF));
            end
            2: begin
               write_csr(REG_FRAME_SIZE, CSR_W'(4096));
               write_csr(REG_FRAME_CNT, CSR_W'(512));
            end
            3: begin
               write_csr(REG_FRAME_SIZE, CSR_W'(1));
               write_csr(REG_FRAME_CNT, CSR_W'(40));
            end
            4: write_csr(REG_FRAME_SIZE, CSR_W'($urandom_range(2, 64)));
            default: write_csr(REG_FRAME_CNT, CSR_W'($urandom_range(16, 200)));
         endcase
         stall_random = (ph != 3);
         random_phase(120);
         wait_drained();
      end

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_ram.sv
hw/rtl/pfa_div.sv
hw/rtl/paged_frame_allocator.sv
hw/rtl/pfa_checker.sv
dv/tb_paged_frame_allocator.sv
